[src/mis_pkg.sv]
package mis_pkg;

	localparam int MAX_DIM   = 4;
	localparam int FRAC_BITS = 16;
	localparam int CELLS     = MAX_DIM * MAX_DIM;
	localparam int CELL_W    = $clog2(CELLS);
	localparam int DATA_W    = 32;
	localparam int WIDE_W    = 64;
	localparam int NUM_W     = WIDE_W + FRAC_BITS;
	localparam int DCTR_W    = $clog2(NUM_W);
	localparam int PROG_DEPTH = 128;
	localparam int PC_W      = $clog2(PROG_DEPTH);
	localparam int NTMP      = 6;
	localparam int TMP_W     = $clog2(NTMP);

	localparam logic [1:0] MD_LOAD  = 2'd0;
	localparam logic [1:0] MD_FIRST = 2'd1;
	localparam logic [1:0] MD_SUB   = 2'd2;
	localparam logic [1:0] MD_ADD   = 2'd3;

	localparam logic [1:0] SRC_MAT = 2'd0;
	localparam logic [1:0] SRC_TMP = 2'd1;
	localparam logic [1:0] SRC_ADJ = 2'd2;

	localparam logic [1:0] DST_NONE = 2'd0;
	localparam logic [1:0] DST_TMP  = 2'd1;
	localparam logic [1:0] DST_ADJ  = 2'd2;
	localparam logic [1:0] DST_DET  = 2'd3;

	localparam logic [0:0] REG_MATRIX_SIZE = 1'd0;

	localparam logic [WIDE_W-1:0] S64_MAX = {1'b0, {(WIDE_W-1){1'b1}}};
	localparam logic [WIDE_W-1:0] S64_MIN = {1'b1, {(WIDE_W-1){1'b0}}};

	typedef struct packed {
		logic [1:0]        mode;
		logic [CELL_W-1:0] a_idx;
		logic [1:0]        b_src;
		logic [CELL_W-1:0] b_idx;
		logic [1:0]        dst;
		logic [CELL_W-1:0] d_idx;
		logic              neg;
	} op_t;

	typedef op_t [PROG_DEPTH-1:0] prog_t;

	function automatic op_t mk_op(logic [1:0] mode, int a, logic [1:0] bs, int b,
			logic [1:0] dst, int d, int neg);
		op_t o;
		o.mode  = mode;
		o.a_idx = CELL_W'(a);
		o.b_src = bs;
		o.b_idx = CELL_W'(b);
		o.dst   = dst;
		o.d_idx = CELL_W'(d);
		o.neg   = (neg % 2) != 0;
		return o;
	endfunction

	function automatic int minor_idx(int x, int y);
		if (x == 2)
			return 0;
		if (x == 1)
			return (y == 3) ? 1 : 2;
		return (y == 3) ? 3 : ((y == 2) ? 4 : 5);
	endfunction

	function automatic int minor_c1(int t);
		return (t == 0) ? 2 : ((t < 3) ? 1 : 0);
	endfunction

	function automatic int minor_c2(int t);
		return (t == 2 || t == 4) ? 2 : ((t == 5) ? 1 : 3);
	endfunction

	function automatic prog_t build_prog(int n);
		prog_t p;
		int pc, g, t, r1, r2, j, c, u, k, i, idx, c1, c2;
		int cs [3];
		p  = '0;
		pc = 0;
		if (n == 4) begin
			for (g = 0; g < 3; g++) begin
				r1 = (g == 0) ? 2 : 1;
				r2 = (g == 2) ? 2 : 3;
				for (t = 0; t < NTMP; t++) begin
					p[pc] = mk_op(MD_FIRST, r1*4 + minor_c1(t), SRC_MAT, r2*4 + minor_c2(t),
						DST_NONE, 0, 0);
					pc = pc + 1;
					p[pc] = mk_op(MD_SUB, r2*4 + minor_c1(t), SRC_MAT, r1*4 + minor_c2(t),
						DST_TMP, t, 0);
					pc = pc + 1;
				end
				for (j = 0; j < 4; j++) begin
					if ((g == 0 && j < 2) || (g == 1 && j == 2) || (g == 2 && j == 3)) begin
						u = 6 - r1 - r2 - j;
						for (c = 0; c < 4; c++) begin
							idx = 0;
							for (i = 0; i < 4; i++) begin
								if (i != c) begin
									cs[idx] = i;
									idx = idx + 1;
								end
							end
							p[pc] = mk_op(MD_FIRST, u*4 + cs[0], SRC_TMP,
								minor_idx(cs[1], cs[2]), DST_NONE, 0, 0);
							pc = pc + 1;
							p[pc] = mk_op(MD_SUB, u*4 + cs[1], SRC_TMP,
								minor_idx(cs[0], cs[2]), DST_NONE, 0, 0);
							pc = pc + 1;
							p[pc] = mk_op(MD_ADD, u*4 + cs[2], SRC_TMP,
								minor_idx(cs[0], cs[1]), DST_ADJ, 4*c + j, c + j);
							pc = pc + 1;
						end
					end
				end
			end
		end else if (n == 3) begin
			for (i = 0; i < 3; i++) begin
				for (j = 0; j < 3; j++) begin
					r1 = (j == 0) ? 1 : 0;
					r2 = (j == 2) ? 1 : 2;
					c1 = (i == 0) ? 1 : 0;
					c2 = (i == 2) ? 1 : 2;
					p[pc] = mk_op(MD_FIRST, r1*3 + c1, SRC_MAT, r2*3 + c2, DST_NONE, 0, 0);
					pc = pc + 1;
					p[pc] = mk_op(MD_SUB, r1*3 + c2, SRC_MAT, r2*3 + c1, DST_ADJ, 3*i + j,
						i + j);
					pc = pc + 1;
				end
			end
		end else begin
			for (i = 0; i < 2; i++) begin
				for (j = 0; j < 2; j++) begin
					p[pc] = mk_op(MD_LOAD, (1 - j)*2 + (1 - i), SRC_MAT, 0, DST_ADJ, 2*i + j,
						i + j);
					pc = pc + 1;
				end
			end
		end
		for (k = 0; k < n; k++) begin
			p[pc] = mk_op((k == 0) ? MD_FIRST : MD_ADD, k, SRC_ADJ, k*n,
				(k == n - 1) ? DST_DET : DST_NONE, 0, 0);
			pc = pc + 1;
		end
		return p;
	endfunction

	localparam prog_t PROG2 = build_prog(2);
	localparam prog_t PROG3 = build_prog(3);
	localparam prog_t PROG4 = build_prog(4);
	localparam logic [PC_W-1:0] PLEN2 = PC_W'(6);
	localparam logic [PC_W-1:0] PLEN3 = PC_W'(21);
	localparam logic [PC_W-1:0] PLEN4 = PC_W'(88);

	function automatic logic [WIDE_W-1:0] mag64(logic [WIDE_W-1:0] x);
		return x[WIDE_W-1] ? (~x + 1'b1) : x;
	endfunction

endpackage

[src/mis_in_if.sv]
interface mis_in_if;
	import mis_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] element_value;
	modport source(output valid, element_value, input ready);
	modport sink(input valid, element_value, output ready);
endinterface

[src/mis_out_if.sv]
interface mis_out_if;
	import mis_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] inv_value;
	logic signed [DATA_W-1:0] det_value;
	logic                     singular;
	logic                     saturated;
	logic                     last_out;
	modport source(output valid, inv_value, det_value, singular, saturated, last_out,
		input ready);
	modport sink(input valid, inv_value, det_value, singular, saturated, last_out,
		output ready);
endinterface

[src/mis_ram.sv]
module mis_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

[src/matrix_inverse_small.sv]
// Loads n*n words (one per cycle when offered), then runs the cofactor program on one
// shared 32x32 multiplier; a multiply-accumulate step reads, multiplies, rounds, accumulates
// and writes back; a plain copy skips the multiply (n=4: 88 steps, n=3: 21, n=2: 6).
// Each inverse word then runs the bit-serial divider (skipped when singular) and waits on
// the output. One matrix at a time; no new word until the last inverse word leaves.
// Reset (arst_n low) sets matrix_size to 4 and clears the load count and all control.
module matrix_inverse_small (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [2:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	mis_in_if.sink                din,
	mis_out_if.source             dout
);
	import mis_pkg::*;

	localparam logic [3:0] ST_LOAD = 4'd0;
	localparam logic [3:0] ST_RDA  = 4'd1;
	localparam logic [3:0] ST_RDB  = 4'd2;
	localparam logic [3:0] ST_OPND = 4'd3;
	localparam logic [3:0] ST_MUL  = 4'd4;
	localparam logic [3:0] ST_RND  = 4'd5;
	localparam logic [3:0] ST_ACC  = 4'd6;
	localparam logic [3:0] ST_WB   = 4'd7;
	localparam logic [3:0] ST_DRD  = 4'd8;
	localparam logic [3:0] ST_DSET = 4'd9;
	localparam logic [3:0] ST_DIV  = 4'd10;
	localparam logic [3:0] ST_DFIN = 4'd11;
	localparam logic [3:0] ST_EMIT = 4'd12;

	logic [3:0]              state_q;
	logic [2:0]              size_q;
	logic [4:0]              cnt_q;
	logic [PC_W-1:0]         pc_q;
	logic [DATA_W-1:0]       a_q;
	logic [WIDE_W-1:0]       ma_q, mb_q;
	logic                    pneg_q;
	logic [2*WIDE_W-1:0]     prod_q;
	logic [1:0]              mctr_q;
	logic [WIDE_W-1:0]       p_q, acc_q, det_q;
	logic                    clip_q;
	logic [WIDE_W-1:0]       tmp_q [NTMP];
	logic [CELL_W-1:0]       k_q;
	logic [NUM_W-1:0]        nd_q, quo_q;
	logic [WIDE_W-1:0]       rem_q;
	logic [DCTR_W-1:0]       dctr_q;
	logic                    qneg_q;
	logic                    ovalid_q, sing_q, sat_q, last_q;
	logic [DATA_W-1:0]       inv_q, detout_q;

	logic [2:0]              dim;
	logic [4:0]              nn;
	logic [PC_W-1:0]         plen;
	op_t                     op;
	logic                    in_acc, cfg_wr;
	logic [CELL_W-1:0]       mat_ra, adj_ra;
	logic [DATA_W-1:0]       mat_rd;
	logic [WIDE_W-1:0]       adj_rd, adj_wd;
	logic                    adj_we;
	logic [WIDE_W-1:0]       a_ext, b_val;
	logic [DATA_W-1:0]       pa_sel, pb_sel;
	logic [WIDE_W-1:0]       pp;
	logic [2*WIDE_W-1:0]     ppx;
	logic [2*WIDE_W-1:0]     rsum;
	logic [WIDE_W-1:0]       rmag, rlim, rsel, rval;
	logic                    rclip;
	logic [WIDE_W:0]         add65, sub65;
	logic [WIDE_W-1:0]       acc_nx;
	logic                    acc_clip;
	logic [WIDE_W-1:0]       wb_val;
	logic                    wb_clip;
	logic                    det_clip, det_zero;
	logic [DATA_W-1:0]       det32;
	logic [WIDE_W-1:0]       dmag;
	logic [WIDE_W:0]         rem2;
	logic                    dge;
	logic                    drnd;
	logic [NUM_W:0]          q1;
	logic [DATA_W-1:0]       qlim, qsel;
	logic                    qclip;

	always_comb begin
		if (size_q < 3'd2)
			dim = 3'd2;
		else if (size_q > 3'(MAX_DIM))
			dim = 3'(MAX_DIM);
		else
			dim = size_q;
	end

	assign nn = 5'(dim) * 5'(dim);

	always_comb begin
		unique case (dim)
			3'd4:    begin op = PROG4[pc_q]; plen = PLEN4; end
			3'd3:    begin op = PROG3[pc_q]; plen = PLEN3; end
			default: begin op = PROG2[pc_q]; plen = PLEN2; end
		endcase
	end

	assign in_acc  = din.valid && din.ready;
	assign din.ready = (state_q == ST_LOAD);
	assign cfg_wr  = psel && penable && pwrite && (paddr[2] == REG_MATRIX_SIZE);
	assign pready  = 1'b1;
	assign prdata  = {29'd0, size_q};

	assign mat_ra = (state_q == ST_RDA) ? op.a_idx : op.b_idx;
	assign adj_ra = (state_q == ST_DRD) ? k_q : op.b_idx;

	mis_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_mat (
		.clk   (clk),
		.we    (in_acc),
		.waddr (cnt_q[CELL_W-1:0]),
		.wdata (din.element_value),
		.raddr (mat_ra),
		.rdata (mat_rd)
	);

	mis_ram #(.WIDTH(WIDE_W), .DEPTH(CELLS)) u_adj (
		.clk   (clk),
		.we    (adj_we),
		.waddr (op.d_idx),
		.wdata (adj_wd),
		.raddr (adj_ra),
		.rdata (adj_rd)
	);

	assign a_ext = {{(WIDE_W-DATA_W){a_q[DATA_W-1]}}, a_q};

	always_comb begin
		unique case (op.b_src)
			SRC_MAT: b_val = {{(WIDE_W-DATA_W){mat_rd[DATA_W-1]}}, mat_rd};
			SRC_TMP: b_val = tmp_q[op.b_idx[TMP_W-1:0]];
			SRC_ADJ: b_val = adj_rd;
			default: b_val = '0;
		endcase
	end

	assign pa_sel = mctr_q[1] ? ma_q[WIDE_W-1:DATA_W] : ma_q[DATA_W-1:0];
	assign pb_sel = mctr_q[0] ? mb_q[WIDE_W-1:DATA_W] : mb_q[DATA_W-1:0];
	assign pp     = pa_sel * pb_sel;
	assign ppx    = (2*WIDE_W)'(pp) << {mctr_q[1] & mctr_q[0], mctr_q[1] ^ mctr_q[0], 5'd0};

	assign rsum  = prod_q + ((2*WIDE_W)'(1) << (FRAC_BITS - 1));
	assign rmag  = rsum[FRAC_BITS +: WIDE_W];
	assign rlim  = pneg_q ? S64_MIN : S64_MAX;
	assign rclip = (|rsum[2*WIDE_W-1:WIDE_W+FRAC_BITS]) || (rmag > rlim);
	assign rsel  = rclip ? rlim : rmag;
	assign rval  = pneg_q ? (~rsel + 1'b1) : rsel;

	assign add65 = {acc_q[WIDE_W-1], acc_q} + {p_q[WIDE_W-1], p_q};
	assign sub65 = {acc_q[WIDE_W-1], acc_q} - {p_q[WIDE_W-1], p_q};

	always_comb begin
		acc_clip = 1'b0;
		unique case (op.mode)
			MD_SUB: begin
				acc_nx = sub65[WIDE_W-1:0];
				if (sub65[WIDE_W] != sub65[WIDE_W-1]) begin
					acc_clip = 1'b1;
					acc_nx   = acc_q[WIDE_W-1] ? S64_MIN : S64_MAX;
				end
			end
			MD_ADD: begin
				acc_nx = add65[WIDE_W-1:0];
				if (add65[WIDE_W] != add65[WIDE_W-1]) begin
					acc_clip = 1'b1;
					acc_nx   = acc_q[WIDE_W-1] ? S64_MIN : S64_MAX;
				end
			end
			default: acc_nx = p_q;
		endcase
	end

	always_comb begin
		wb_clip = 1'b0;
		wb_val  = acc_q;
		if (op.neg) begin
			if (acc_q == S64_MIN) begin
				wb_clip = 1'b1;
				wb_val  = S64_MAX;
			end else begin
				wb_val = ~acc_q + 1'b1;
			end
		end
	end

	assign adj_we = (state_q == ST_WB) && (op.dst == DST_ADJ);
	assign adj_wd = wb_val;

	assign det_zero = (det_q == '0);
	assign det_clip = !((&det_q[WIDE_W-1:DATA_W-1]) || !(|det_q[WIDE_W-1:DATA_W-1]));
	assign det32    = det_clip ? (det_q[WIDE_W-1] ? 32'h8000_0000 : 32'h7fff_ffff)
		: det_q[DATA_W-1:0];
	assign dmag     = mag64(det_q);

	assign rem2 = {rem_q, nd_q[NUM_W-1]};
	assign dge  = rem2 >= {1'b0, dmag};
	assign drnd = rem_q >= (dmag - rem_q);
	assign q1   = {1'b0, quo_q} + (NUM_W+1)'(drnd);
	assign qlim = qneg_q ? 32'h8000_0000 : 32'h7fff_ffff;
	assign qclip = q1 > (NUM_W+1)'(qlim);
	assign qsel = qclip ? qlim : q1[DATA_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_LOAD;
			size_q   <= 3'(MAX_DIM);
			cnt_q    <= '0;
			pc_q     <= '0;
			k_q      <= '0;
			mctr_q   <= '0;
			dctr_q   <= '0;
			clip_q   <= 1'b0;
			det_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				size_q <= pwdata[2:0];
				cnt_q  <= '0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (cnt_q + 5'd1 >= nn) begin
							cnt_q   <= '0;
							pc_q    <= '0;
							clip_q  <= 1'b0;
							state_q <= ST_RDA;
						end else begin
							cnt_q <= cnt_q + 5'd1;
						end
					end
				end
				ST_RDA: state_q <= ST_RDB;
				ST_RDB: begin
					a_q     <= mat_rd;
					state_q <= ST_OPND;
				end
				ST_OPND: begin
					if (op.mode == MD_LOAD) begin
						p_q     <= a_ext;
						state_q <= ST_ACC;
					end else begin
						ma_q    <= mag64(a_ext);
						mb_q    <= mag64(b_val);
						pneg_q  <= a_ext[WIDE_W-1] ^ b_val[WIDE_W-1];
						prod_q  <= '0;
						mctr_q  <= '0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					prod_q <= prod_q + ppx;
					mctr_q <= mctr_q + 2'd1;
					if (mctr_q == 2'd3)
						state_q <= ST_RND;
				end
				ST_RND: begin
					p_q <= rval;
					if (rclip)
						clip_q <= 1'b1;
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					acc_q <= acc_nx;
					if (acc_clip)
						clip_q <= 1'b1;
					state_q <= ST_WB;
				end
				ST_WB: begin
					if (wb_clip)
						clip_q <= 1'b1;
					if (op.dst == DST_TMP)
						tmp_q[op.d_idx[TMP_W-1:0]] <= wb_val;
					if (op.dst == DST_DET)
						det_q <= wb_val;
					if (pc_q == plen - 1'b1) begin
						k_q     <= '0;
						state_q <= ST_DRD;
					end else begin
						pc_q    <= pc_q + 1'b1;
						state_q <= ST_RDA;
					end
				end
				ST_DRD: state_q <= ST_DSET;
				ST_DSET: begin
					nd_q    <= {mag64(adj_rd), {FRAC_BITS{1'b0}}};
					rem_q   <= '0;
					quo_q   <= '0;
					dctr_q  <= '0;
					qneg_q  <= adj_rd[WIDE_W-1] ^ det_q[WIDE_W-1];
					state_q <= det_zero ? ST_DFIN : ST_DIV;
				end
				ST_DIV: begin
					nd_q   <= nd_q << 1;
					rem_q  <= dge ? WIDE_W'(rem2 - {1'b0, dmag}) : rem2[WIDE_W-1:0];
					quo_q  <= {quo_q[NUM_W-2:0], dge};
					dctr_q <= dctr_q + 1'b1;
					if (dctr_q == DCTR_W'(NUM_W - 1))
						state_q <= ST_DFIN;
				end
				ST_DFIN: begin
					inv_q    <= det_zero ? '0 : (qneg_q ? (~qsel + 1'b1) : qsel);
					detout_q <= det32;
					sing_q   <= det_zero;
					sat_q    <= clip_q || det_clip || (!det_zero && qclip);
					last_q   <= (5'(k_q) + 5'd1 == nn);
					ovalid_q <= 1'b1;
					state_q  <= ST_EMIT;
				end
				ST_EMIT: begin
					if (dout.ready) begin
						ovalid_q <= 1'b0;
						if (last_q) begin
							state_q <= ST_LOAD;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= ST_DRD;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	assign dout.valid     = ovalid_q;
	assign dout.inv_value = inv_q;
	assign dout.det_value = detout_q;
	assign dout.singular  = sing_q;
	assign dout.saturated = sat_q;
	assign dout.last_out  = last_q;

`ifndef SYNTHESIS
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(din.ready && dout.valid))
		else $error("input taken while an inverse word is pending");

	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(dout.valid && dout.singular) |-> (dout.inv_value == '0 && dout.det_value == '0))
		else $error("singular word carries nonzero data");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD) |-> (cnt_q < nn))
		else $error("load count beyond matrix size");
`endif
endmodule

[test/matrix_inverse_small_tb.sv]
module matrix_inverse_small_tb;
	import mis_pkg::*;

	localparam int LIMIT_CYCLES = 1000000;
	localparam int RANDOM_WORDS = 250;
	localparam int DRAIN_WAIT   = 40;
	localparam logic [2:0] ADDR_MATRIX_SIZE = 3'(REG_MATRIX_SIZE) << 2;
	localparam longint S64_TOP = 64'sh7fffffffffffffff;
	localparam longint S64_BOT = 64'sh8000000000000000;
	localparam logic [31:0] ONE_Q = 32'h0001_0000;

	typedef struct {
		logic [31:0] inv;
		logic [31:0] det;
		logic        sing;
		logic        sat;
		logic        last;
	} inverse_word_t;

	typedef struct {
		bit          cfg;
		logic [2:0]  size;
		logic [31:0] word;
		bit          typed;
		logic [31:0] t_inv;
		logic [31:0] t_det;
		logic        t_sing;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	mis_in_if  din_if();
	mis_out_if dout_if();

	matrix_inverse_small i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.din(din_if),
		.dout(dout_if)
	);

	inverse_word_t pending_inverse[$];
	int            fail_count;
	int            cycle_count;
	bit            quiet;
	int            out_stall;

	logic [2:0] size_reg;
	longint     mat_q[16];
	longint     adj_q[16];
	int         word_count;
	bit         calc_clip;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic longint sat_add(longint a, longint b);
		longint r;
		r = a + b;
		if ((a < 0) == (b < 0) && (r < 0) != (a < 0)) begin
			calc_clip = 1'b1;
			return (a < 0) ? S64_BOT : S64_TOP;
		end
		return r;
	endfunction

	function automatic longint sat_sub(longint a, longint b);
		longint r;
		r = a - b;
		if ((a < 0) != (b < 0) && (r < 0) != (a < 0)) begin
			calc_clip = 1'b1;
			return (a < 0) ? S64_BOT : S64_TOP;
		end
		return r;
	endfunction

	function automatic longint sat_neg(longint a);
		if (a == S64_BOT) begin
			calc_clip = 1'b1;
			return S64_TOP;
		end
		return -a;
	endfunction

	function automatic longint q_mul(longint a, longint b);
		logic signed [127:0] pa, pb, p;
		logic [127:0]        mag, lim;
		bit                  neg;
		pa = 128'(a);
		pb = 128'(b);
		p = pa * pb;
		neg = p < 0;
		mag = neg ? -p : p;
		mag = (mag + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		lim = neg ? (128'd1 << 63) : ((128'd1 << 63) - 1);
		if (mag > lim) begin
			calc_clip = 1'b1;
			mag = lim;
		end
		return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
	endfunction

	function automatic longint q_div32(longint num, longint den, ref bit clip);
		logic [127:0] un, d, q, rem, lim;
		bit           neg;
		neg = (num < 0) != (den < 0);
		un = (num < 0) ? 128'(-num) & {64'd0, {64{1'b1}}} : 128'(num);
		d = (den < 0) ? 128'(-den) & {64'd0, {64{1'b1}}} : 128'(den);
		un = un << FRAC_BITS;
		q = un / d;
		rem = un % d;
		if (rem >= d - rem)
			q = q + 1;
		lim = neg ? (128'd1 << 31) : ((128'd1 << 31) - 1);
		if (q > lim) begin
			clip = 1'b1;
			q = lim;
		end
		return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
	endfunction

	function automatic longint dm(longint x, longint y, longint z, longint w);
		return sat_sub(q_mul(x, y), q_mul(z, w));
	endfunction

	function automatic longint tri3(longint x0, longint t0, longint x1, longint t1,
			longint x2, longint t2);
		return sat_add(sat_sub(q_mul(x0, t0), q_mul(x1, t1)), q_mul(x2, t2));
	endfunction

	task automatic adjugate4();
		longint a, b, c, d, e, f, g, h, i, j, k, l, mm, n, o, p;
		longint t0, t1, t2, t3, t4, t5;
		a = mat_q[0]; b = mat_q[1]; c = mat_q[2]; d = mat_q[3];
		e = mat_q[4]; f = mat_q[5]; g = mat_q[6]; h = mat_q[7];
		i = mat_q[8]; j = mat_q[9]; k = mat_q[10]; l = mat_q[11];
		mm = mat_q[12]; n = mat_q[13]; o = mat_q[14]; p = mat_q[15];
		t0 = dm(k, p, o, l); t1 = dm(j, p, n, l); t2 = dm(j, o, n, k);
		t3 = dm(i, p, mm, l); t4 = dm(i, o, mm, k); t5 = dm(i, n, mm, j);
		adj_q[0] = tri3(f, t0, g, t1, h, t2);
		adj_q[4] = sat_neg(tri3(e, t0, g, t3, h, t4));
		adj_q[8] = tri3(e, t1, f, t3, h, t5);
		adj_q[12] = sat_neg(tri3(e, t2, f, t4, g, t5));
		adj_q[1] = sat_neg(tri3(b, t0, c, t1, d, t2));
		adj_q[5] = tri3(a, t0, c, t3, d, t4);
		adj_q[9] = sat_neg(tri3(a, t1, b, t3, d, t5));
		adj_q[13] = tri3(a, t2, b, t4, c, t5);
		t0 = dm(g, p, o, h); t1 = dm(f, p, n, h); t2 = dm(f, o, n, g);
		t3 = dm(e, p, mm, h); t4 = dm(e, o, mm, g); t5 = dm(e, n, mm, f);
		adj_q[2] = tri3(b, t0, c, t1, d, t2);
		adj_q[6] = sat_neg(tri3(a, t0, c, t3, d, t4));
		adj_q[10] = tri3(a, t1, b, t3, d, t5);
		adj_q[14] = sat_neg(tri3(a, t2, b, t4, c, t5));
		t0 = dm(g, l, k, h); t1 = dm(f, l, j, h); t2 = dm(f, k, j, g);
		t3 = dm(e, l, i, h); t4 = dm(e, k, i, g); t5 = dm(e, j, i, f);
		adj_q[3] = sat_neg(tri3(b, t0, c, t1, d, t2));
		adj_q[7] = tri3(a, t0, c, t3, d, t4);
		adj_q[11] = sat_neg(tri3(a, t1, b, t3, d, t5));
		adj_q[15] = tri3(a, t2, b, t4, c, t5);
	endtask

	task automatic adjugate3();
		longint a, b, c, d, e, f, g, h, i;
		a = mat_q[0]; b = mat_q[1]; c = mat_q[2]; d = mat_q[3]; e = mat_q[4];
		f = mat_q[5]; g = mat_q[6]; h = mat_q[7]; i = mat_q[8];
		adj_q[0] = dm(e, i, f, h);
		adj_q[1] = sat_neg(dm(b, i, h, c));
		adj_q[2] = dm(b, f, e, c);
		adj_q[3] = sat_neg(dm(d, i, g, f));
		adj_q[4] = dm(a, i, c, g);
		adj_q[5] = sat_neg(dm(a, f, d, c));
		adj_q[6] = dm(d, h, g, e);
		adj_q[7] = sat_neg(dm(a, h, g, b));
		adj_q[8] = dm(a, e, b, d);
	endtask

	function automatic int dim_now();
		if (size_reg < 2)
			return 2;
		if (size_reg > MAX_DIM)
			return MAX_DIM;
		return int'(size_reg);
	endfunction

	// returns the number of inverse words this word releases
	task automatic invert_on_word(input logic [31:0] w, output int produced);
		int            n, nn, k;
		longint        det, det_c;
		bit            det_clip, sing, clip;
		inverse_word_t r;
		n = dim_now();
		nn = n * n;
		produced = 0;
		if (word_count >= nn)
			word_count = 0;
		mat_q[word_count % 16] = longint'($signed(w));
		word_count++;
		if (word_count < nn)
			return;
		word_count = 0;
		calc_clip = 1'b0;
		if (n == 2) begin
			adj_q[0] = mat_q[3];
			adj_q[1] = sat_neg(mat_q[1]);
			adj_q[2] = sat_neg(mat_q[2]);
			adj_q[3] = mat_q[0];
		end else if (n == 3) begin
			adjugate3();
		end else begin
			adjugate4();
		end
		det = 0;
		for (k = 0; k < n; k++)
			det = sat_add(det, q_mul(mat_q[k], adj_q[k * n]));
		sing = det == 0;
		det_clip = 1'b0;
		det_c = det;
		if (det > longint'(32'sh7fffffff)) begin
			det_c = longint'(32'sh7fffffff);
			det_clip = 1'b1;
		end else if (det < -longint'(64'h80000000)) begin
			det_c = -longint'(64'h80000000);
			det_clip = 1'b1;
		end
		for (k = 0; k < nn; k++) begin
			clip = 1'b0;
			r.inv = sing ? 32'd0 : 32'(q_div32(adj_q[k], det, clip));
			r.det = det_c[31:0];
			r.sing = sing;
			r.sat = clip || det_clip || calc_clip;
			r.last = (k + 1 == nn);
			pending_inverse.push_back(r);
		end
		produced = nn;
	endtask

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic drain();
		while (pending_inverse.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic set_size(input logic [2:0] sz);
		apb_write(ADDR_MATRIX_SIZE, {29'd0, sz});
		size_reg = sz;
		word_count = 0;
	endtask

	task automatic idle_gap();
		int g;
		g = $urandom_range(1, 14);
		din_if.valid <= 1'b0;
		repeat (g) @(posedge clk);
	endtask

	task automatic send_word(input logic [31:0] w, output int produced);
		if (!quiet && $urandom_range(0, 5) == 0)
			idle_gap();
		@(posedge clk);
		din_if.valid <= 1'b1;
		din_if.element_value <= w;
		@(posedge clk);
		while (!din_if.ready)
			@(posedge clk);
		invert_on_word(w, produced);
		// drop valid; the next word raises it at a fresh edge
		din_if.valid <= 1'b0;
	endtask

	function automatic logic [31:0] pick_word(int style);
		case (style)
			0: return 32'($signed($urandom_range(0, 8 * 65536)) - 4 * 65536);
			1: return $urandom;
			default: begin
				case ($urandom_range(0, 5))
					0: return 32'h7fffffff;
					1: return 32'h80000000;
					2: return 32'h0;
					3: return ONE_Q;
					4: return -ONE_Q;
					default: return 32'h1;
				endcase
			end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout_if.ready <= 1'b0;
			out_stall <= 0;
		end else if (quiet) begin
			dout_if.ready <= 1'b1;
		end else if (out_stall > 0) begin
			out_stall <= out_stall - 1;
			dout_if.ready <= 1'b0;
		end else if ($urandom_range(0, 9) == 0) begin
			out_stall <= $urandom_range(1, 14) - 1;
			dout_if.ready <= 1'b0;
		end else begin
			dout_if.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		inverse_word_t e;
		if (arst_n && dout_if.valid && dout_if.ready) begin
			if (pending_inverse.size() == 0) begin
				$display("%0t: unexpected word inv=%h", $time, dout_if.inv_value);
				fail_count++;
			end else begin
				e = pending_inverse.pop_front();
				if (dout_if.inv_value !== e.inv || dout_if.det_value !== e.det ||
						dout_if.singular !== e.sing || dout_if.saturated !== e.sat ||
						dout_if.last_out !== e.last) begin
					$display("%0t: expected inv=%h det=%h sing=%b sat=%b last=%b", $time,
						e.inv, e.det, e.sing, e.sat, e.last);
					$display("%0t: actual   inv=%h det=%h sing=%b sat=%b last=%b", $time,
						dout_if.inv_value, dout_if.det_value, dout_if.singular,
						dout_if.saturated, dout_if.last_out);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		dir_row_t dir_tab[21];
		logic [31:0] mat[16];
		logic [2:0]  sizes[8];
		int r, k, n, style, produced, sent, phase, dup;
		fail_count = 0;
		cycle_count = 0;
		quiet = 1'b0;
		size_reg = 3'd4;
		word_count = 0;
		arst_n = 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		din_if.valid <= 1'b0;
		din_if.element_value <= '0;
		dir_tab = '{
			'{1, 3'd2, ONE_Q, 0, 0, 0, 0},
			'{0, 3'd0, 32'h0, 0, 0, 0, 0},
			'{0, 3'd0, 32'h0, 0, 0, 0, 0},
			'{0, 3'd0, ONE_Q, 1, ONE_Q, ONE_Q, 0},
			'{0, 3'd0, 32'h0, 0, 0, 0, 0},
			'{0, 3'd0, 32'h0, 0, 0, 0, 0},
			'{0, 3'd0, 32'h0, 0, 0, 0, 0},
			'{0, 3'd0, 32'h0, 1, 32'h0, 32'h0, 1},
			'{0, 3'd0, 32'h7fffffff, 0, 0, 0, 0},
			'{0, 3'd0, 32'h80000000, 0, 0, 0, 0},
			'{0, 3'd0, 32'h80000000, 0, 0, 0, 0},
			'{0, 3'd0, 32'h7fffffff, 0, 0, 0, 0},
			'{1, 3'd3, ONE_Q, 0, 0, 0, 0},
			'{0, 3'd0, 32'h0, 0, 0, 0, 0},
			'{0, 3'd0, 32'h0, 0, 0, 0, 0},
			'{0, 3'd0, 32'h0, 0, 0, 0, 0},
			'{0, 3'd0, ONE_Q, 0, 0, 0, 0},
			'{0, 3'd0, 32'h0, 0, 0, 0, 0},
			'{0, 3'd0, 32'h0, 0, 0, 0, 0},
			'{0, 3'd0, 32'h0, 0, 0, 0, 0},
			'{0, 3'd0, ONE_Q, 1, ONE_Q, ONE_Q, 0}
		};
		sizes = '{3'd4, 3'd2, 3'd7, 3'd3, 3'd0, 3'd4, 3'd1, 3'd5};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		for (r = 0; r < 21; r++) begin
			if (dir_tab[r].cfg) begin
				drain();
				set_size(dir_tab[r].size);
			end
			send_word(dir_tab[r].word, produced);
			if (dir_tab[r].typed && produced > 0) begin
				k = pending_inverse.size() - produced;
				pending_inverse[k].inv = dir_tab[r].t_inv;
				pending_inverse[k].det = dir_tab[r].t_det;
				pending_inverse[k].sing = dir_tab[r].t_sing;
			end
		end

		// restart a half-loaded matrix with a new size
		drain();
		set_size(3'd4);
		for (k = 0; k < 5; k++)
			send_word(pick_word(1), produced);
		repeat (DRAIN_WAIT) @(posedge clk);
		set_size(3'd2);

		sent = 0;
		phase = 0;
		while (sent < RANDOM_WORDS) begin
			if (sent > RANDOM_WORDS - 40)
				quiet = 1'b1;
			if ($urandom_range(0, 2) == 0) begin
				drain();
				set_size(sizes[phase % 8]);
				phase++;
			end
			n = dim_now();
			style = $urandom_range(0, 19);
			for (k = 0; k < n * n; k++)
				mat[k] = pick_word(style < 12 ? 0 : (style < 15 ? 1 : 2));
			if (style >= 17) begin
				dup = $urandom_range(1, n - 1);
				for (k = 0; k < n; k++)
					mat[dup * n + k] = (style == 19) ? 32'h0 : mat[k];
			end
			for (k = 0; k < n * n; k++)
				send_word(mat[k], produced);
			sent += n * n;
		end

		drain();
		repeat (100) @(posedge clk);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

[sim.f]
src/mis_pkg.sv
src/mis_in_if.sv
src/mis_out_if.sv
src/mis_ram.sv
src/matrix_inverse_small.sv
test/matrix_inverse_small_tb.sv
